// ----- rtl/core/afk_pkg.sv -----
// ============================================================================
// afk_pkg: shared types and constants for the arm forward kinematics block
// Holds the CORDIC arctangent table, fixed-point widths and register indexes.
// ============================================================================
`default_nettype none

package afk_pkg;

    localparam int AngleFracBitsDefault = 7;
    localparam int DegFrac     = 16;
    localparam int CordicSteps = 16;
    localparam int LinkW       = 15;
    localparam int AngleW      = 16;
    localparam int OutW        = 17;
    localparam int TrigW       = 26;   // Q24 sine/cosine, signed
    localparam int ZW          = 27;   // CORDIC residual angle, Q16 degrees
    localparam int RedW        = 27;   // reduced angle, Q16 degrees
    localparam int ReachW      = 30;   // r1 and r3, Q24, signed; r1 sums two links

    localparam logic signed [TrigW-1:0] CordicGain = TrigW'(10188014);
    localparam logic signed [RedW-1:0]  FullTurn    = RedW'(360 * 65536);
    localparam logic signed [RedW-1:0]  HalfTurn    = RedW'(180 * 65536);
    localparam logic signed [RedW-1:0]  QuarterTurn = RedW'(90 * 65536);

    localparam logic [1:0] RegLinkOne   = 2'd0;
    localparam logic [1:0] RegLinkTwo   = 2'd1;
    localparam logic [1:0] RegLinkThree = 2'd2;

    localparam logic [LinkW-1:0] LinkReset = LinkW'(4096);

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = ZW'(2949120);
                1: v = ZW'(1740967);
                2: v = ZW'(919879);
                3: v = ZW'(466945);
                4: v = ZW'(234379);
                5: v = ZW'(117304);
                6: v = ZW'(58666);
                7: v = ZW'(29335);
                8: v = ZW'(14668);
                9: v = ZW'(7334);
                10: v = ZW'(3667);
                11: v = ZW'(1833);
                12: v = ZW'(917);
                13: v = ZW'(458);
                14: v = ZW'(229);
                15: v = ZW'(115);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Pipeline bookkeeping carried alongside each CORDIC lane.
    typedef struct packed {
        logic signed [TrigW-1:0] x;
        logic signed [TrigW-1:0] y;
        logic signed [ZW-1:0]    z;
        logic                    flip;
    } cordic_lane_t;

endpackage

`default_nettype wire

// ----- rtl/core/afk_sincos.sv -----
// ============================================================================
// afk_sincos: pipelined CORDIC sine and cosine of an angle in degrees
// Reduces the angle to [-90,90] and runs one rotation per register stage.
// ============================================================================
`default_nettype none

module afk_sincos
    import afk_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = AngleFracBitsDefault,
    parameter int IN_W = AngleW + 2
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [IN_W-1:0]   angle,
    output logic signed [TrigW-1:0]       sin_out,
    output logic signed [TrigW-1:0]       cos_out
);

    // One turn is 45 * 2^(frac+3) raw units, so the turn count is the angle
    // in units of eight degrees divided by 45, done by reciprocal multiply.
    localparam int TurnShift = ANGLE_FRAC_BITS + 3;
    localparam int HalfW     = ANGLE_FRAC_BITS + 9;
    localparam int AW        = ((IN_W > HalfW) ? IN_W : HalfW) + 2;
    localparam int MW        = AW - TurnShift;
    localparam int UW        = MW + 5;
    localparam int RS        = UW + 6;
    localparam longint RecipL = ((longint'(1) <<< RS) + 44) / 45;
    localparam logic [UW:0]           Recip      = (UW+1)'(RecipL);
    localparam logic [UW-1:0]         TurnBias   = UW'(45 * (1 << (MW - 1)));
    localparam logic signed [AW-1:0]  TurnOffset = AW'(1 << (MW - 1));
    localparam logic signed [AW-1:0]  HalfRaw    = AW'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0]  TurnRaw    = AW'(360 * (1 << ANGLE_FRAC_BITS));

    logic signed [AW-1:0]   raw_ext;
    logic signed [AW-1:0]   shifted;
    logic signed [MW-1:0]   eighths;
    logic [UW-1:0]          biased;
    logic [2*UW:0]          quot_prod;
    logic signed [AW-1:0]   turns;
    logic signed [AW-1:0]   wrapped_raw;
    logic signed [RedW-1:0] wrapped;
    logic signed [RedW-1:0] folded;
    logic                   flip;

    logic signed [AW-1:0]   raw_reg;
    logic signed [AW-1:0]   turns_reg;
    cordic_lane_t           lane_reg [CordicSteps+1];

    // Count whole turns so that the remainder lands in [-180,180).
    always_comb
    begin
        raw_ext   = AW'(angle);
        shifted   = raw_ext + HalfRaw;
        eighths   = MW'(shifted >>> TurnShift);
        biased    = UW'(eighths) + TurnBias;
        quot_prod = (2*UW+1)'(biased) * (2*UW+1)'(Recip);
        turns     = AW'(quot_prod[2*UW:RS]) - TurnOffset;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg   <= raw_ext;
            turns_reg <= turns;
        end
    end

    always_comb
    begin
        wrapped_raw = raw_reg - turns_reg * TurnRaw;
        wrapped = RedW'(wrapped_raw) <<< (DegFrac - ANGLE_FRAC_BITS);
        flip = 1'b0;
        folded = wrapped;
        if (wrapped > QuarterTurn)
        begin
            folded = HalfTurn - wrapped;
            flip = 1'b1;
        end
        else if (wrapped < -QuarterTurn)
        begin
            folded = -HalfTurn - wrapped;
            flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0].x    <= CordicGain;
            lane_reg[0].y    <= '0;
            lane_reg[0].z    <= ZW'(folded);
            lane_reg[0].flip <= flip;
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        cordic_lane_t nxt;
        always_comb
        begin
            nxt.flip = lane_reg[i].flip;
            if (lane_reg[i].z >= 0)
            begin
                nxt.x = lane_reg[i].x - (lane_reg[i].y >>> i);
                nxt.y = lane_reg[i].y + (lane_reg[i].x >>> i);
                nxt.z = lane_reg[i].z - atan_q16(i);
            end
            else
            begin
                nxt.x = lane_reg[i].x + (lane_reg[i].y >>> i);
                nxt.y = lane_reg[i].y - (lane_reg[i].x >>> i);
                nxt.z = lane_reg[i].z + atan_q16(i);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                lane_reg[i+1] <= nxt;
        end
    end

    assign sin_out = lane_reg[CordicSteps].y;
    assign cos_out = lane_reg[CordicSteps].flip ? -lane_reg[CordicSteps].x
                                                : lane_reg[CordicSteps].x;

endmodule

`default_nettype wire

// ----- rtl/core/arm_forward_kinematics.sv -----
// ============================================================================
// arm_forward_kinematics: tool-tip position of a three-link swiveling arm
// Five joint angles in, one x/y/z position out, fully pipelined.
// ============================================================================
// One pose is accepted every clock cycle when the output side is not stalled.
// The pipeline holds the input stage and five parallel CORDIC pipelines (one
// turn-count stage, one wrap-and-seed stage and sixteen rotation stages),
// followed by the link multiply, a rounding stage, the swivel multiply and
// the final rounding and saturation. The whole pipeline advances only when
// the output register is free or being taken, so a stall holds every item in
// place. Link lengths are written through the configuration channel, which
// is always ready; they should only change while no pose is in flight.
`default_nettype none

module arm_forward_kinematics
    import afk_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = AngleFracBitsDefault
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [AngleW-1:0] base_swivel,
    input  wire logic signed [AngleW-1:0] pitch_one,
    input  wire logic signed [AngleW-1:0] pitch_two,
    input  wire logic signed [AngleW-1:0] pitch_three,
    input  wire logic signed [AngleW-1:0] tip_swivel,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [OutW-1:0]        pos_x,
    output logic signed [OutW-1:0]        pos_y,
    output logic signed [OutW-1:0]        pos_z,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [LinkW-1:0]         cfg_data
);

    localparam int SumW = AngleW + 2;
    // Input stage, CORDIC (reduce, seed, 16 steps), then four math stages.
    localparam int Depth = 1 + 2 + CordicSteps + 4;

    logic [LinkW-1:0] link_one_reg, link_two_reg, link_three_reg;
    logic [Depth-1:0] valid_reg;
    logic             advance;

    // The entire pipeline moves together whenever the last stage can move.
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;
    assign out_valid = valid_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_one_reg   <= LinkReset;
            link_two_reg   <= LinkReset;
            link_three_reg <= LinkReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegLinkOne:   link_one_reg   <= cfg_data;
                RegLinkTwo:   link_two_reg   <= cfg_data;
                RegLinkThree: link_three_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[Depth-2:0], in_valid};
    end

    // Stage 0: form the joint angle sums exactly.
    logic signed [SumW-1:0] ang_reg [5];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ang_reg[0] <= SumW'(pitch_one);
            ang_reg[1] <= SumW'(pitch_one) + SumW'(pitch_two);
            ang_reg[2] <= SumW'(pitch_one) + SumW'(pitch_two) + SumW'(pitch_three);
            ang_reg[3] <= SumW'(base_swivel);
            ang_reg[4] <= SumW'(base_swivel) + SumW'(tip_swivel);
        end
    end

    logic signed [TrigW-1:0] sn [5];
    logic signed [TrigW-1:0] cs [5];

    for (genvar k = 0; k < 5; k++)
    begin : g_trig
        afk_sincos #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
            .IN_W            (SumW)
        ) u_sincos (
            .clk     (clk),
            .en      (advance),
            .angle   (ang_reg[k]),
            .sin_out (sn[k]),
            .cos_out (cs[k])
        );
    end

    // Stage A: link length times sine, Q36.
    localparam int ProdW = TrigW + LinkW + 1;
    logic signed [ProdW-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [TrigW-1:0] sb_a_reg, cb_a_reg, st_a_reg, ct_a_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg   <= $signed({1'b0, link_one_reg})   * sn[0];
            pb_reg   <= $signed({1'b0, link_two_reg})   * sn[1];
            pc_reg   <= $signed({1'b0, link_three_reg}) * sn[2];
            sb_a_reg <= sn[3];
            cb_a_reg <= cs[3];
            st_a_reg <= sn[4];
            ct_a_reg <= cs[4];
        end
    end

    // Stage B: round the reaches to Q24.
    logic signed [ProdW:0]    r1_full, r3_full;
    logic signed [ReachW-1:0] r1_reg, r3_reg;
    logic signed [TrigW-1:0]  sb_b_reg, cb_b_reg, st_b_reg, ct_b_reg;

    always_comb
    begin
        r1_full = ((ProdW+1)'(pa_reg) + (ProdW+1)'(pb_reg) + (ProdW+1)'(2048)) >>> 12;
        r3_full = ((ProdW+1)'(pc_reg) + (ProdW+1)'(2048)) >>> 12;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r1_reg   <= ReachW'(r1_full);
            r3_reg   <= ReachW'(r3_full);
            sb_b_reg <= sb_a_reg;
            cb_b_reg <= cb_a_reg;
            st_b_reg <= st_a_reg;
            ct_b_reg <= ct_a_reg;
        end
    end

    // Stage C: swivel products, Q48, and the z reach sum, Q24.
    localparam int MulW = TrigW + ReachW;
    logic signed [MulW-1:0]   xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [ReachW:0]   zs_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xa_reg <= MulW'(cb_b_reg) * MulW'(r1_reg);
            xb_reg <= MulW'(ct_b_reg) * MulW'(r3_reg);
            ya_reg <= MulW'(sb_b_reg) * MulW'(r1_reg);
            yb_reg <= MulW'(st_b_reg) * MulW'(r3_reg);
            zs_reg <= (ReachW+1)'(r1_reg) + (ReachW+1)'(r3_reg);
        end
    end

    // Stage D: round to Q12 and saturate.
    function automatic logic signed [OutW-1:0] sat(input logic signed [MulW:0] v);
        logic signed [OutW-1:0] r;
        begin
            if (v > (MulW+1)'(65535))
                r = OutW'(65535);
            else if (v < -(MulW+1)'(65536))
                r = OutW'(-65536);
            else
                r = OutW'(v);
            return r;
        end
    endfunction

    logic signed [MulW:0] xr, yr, zr;
    logic signed [MulW:0] half36;

    always_comb
    begin
        half36 = (MulW+1)'(1) <<< 35;
        xr = ((MulW+1)'(xa_reg) + (MulW+1)'(xb_reg) + half36) >>> 36;
        yr = ((MulW+1)'(ya_reg) + (MulW+1)'(yb_reg) + half36) >>> 36;
        zr = ((MulW+1)'(zs_reg) + (MulW+1)'(2048)) >>> 12;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_x <= sat(xr);
            pos_y <= sat(yr);
            pos_z <= sat(zr);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/afk_checker.sv -----
// ============================================================================
// afk_checker: port-level checks for the arm forward kinematics block
// Watches the handshakes on the top level and is bound to it.
// ============================================================================
`default_nettype none

module afk_checker
    import afk_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic signed [OutW-1:0] pos_x,
    input wire logic                  cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x))
        else $error("result dropped while stalled");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config not ready");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
